// File: hw/rtl/spd_pkg.sv
// Shared types and constants for the sensor packet deframer.
`default_nettype none

package spd_pkg;

   // Default build-time limits
   localparam int MAX_SENSORS_DEFAULT = 32;
   localparam int MAX_CHUNKS_DEFAULT  = 64;

   localparam logic [3:0] TYPE_CODE_RESET = 4'd2;

   // Header byte positions
   localparam logic [3:0] POS_TYPE     = 4'd0;
   localparam logic [3:0] POS_VERSION  = 4'd1;
   localparam logic [3:0] POS_TIME_LO  = 4'd2;
   localparam logic [3:0] POS_TIME_HI  = 4'd5;
   localparam logic [3:0] POS_CHUNKS   = 4'd6;
   localparam logic [3:0] POS_SENSORS  = 4'd7;
   localparam logic [3:0] POS_BODY     = 4'd8;

   localparam int HEADER_BYTES    = 8;
   localparam int CHUNK_HEAD_BYTES = 4;
   localparam int DATAPOINT_BYTES = 5;

   localparam logic [2:0] FIELD_LAST_TIME  = 3'd3;
   localparam logic [2:0] FIELD_LAST_VALUE = 3'd4;

   // Result kinds
   localparam logic KIND_DATAPOINT = 1'b0;
   localparam logic KIND_STATUS    = 1'b1;

   // Status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEADER  = 3'd1;
   localparam logic [2:0] STATUS_BAD_SENSORS = 3'd2;
   localparam logic [2:0] STATUS_BAD_CHUNKS  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED   = 3'd4;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_of_packet;
      logic [15:0] packet_length;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  status_code;
      logic [7:0]  packet_version;
      logic [31:0] packet_time;
      logic [5:0]  chunk_number;
      logic [31:0] chunk_time;
      logic [4:0]  sensor_number;
      logic [7:0]  sensor_tag;
      logic [31:0] sensor_value;
      logic        last_of_packet;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/spd_parser.sv
// Per-byte packet parser: header checks, chunk and datapoint assembly.
`default_nettype none

module spd_parser #(
   parameter int MAX_SENSORS = spd_pkg::MAX_SENSORS_DEFAULT,
   parameter int MAX_CHUNKS  = spd_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire spd_pkg::req_type item,
   input  wire logic [3:0]       type_code,
   output spd_pkg::rsp_type      result,
   output logic                  result_valid
);

   localparam int SCW   = $clog2(MAX_SENSORS + 1);
   localparam int CCW   = $clog2(MAX_CHUNKS + 1);
   localparam int EXP_W = $clog2(spd_pkg::HEADER_BYTES + MAX_CHUNKS *
                         (spd_pkg::CHUNK_HEAD_BYTES + spd_pkg::DATAPOINT_BYTES * MAX_SENSORS) + 1);

   logic [3:0]     pos_ff, pos_in;
   logic [15:0]    length_ff, length_in;
   logic [7:0]     version_ff, version_in;
   logic [31:0]    ptime_ff, ptime_in;
   logic [7:0]     chunk_total_ff, chunk_total_in;
   logic [7:0]     sensor_total_ff, sensor_total_in;
   logic [CCW-1:0] chunk_cnt_ff, chunk_cnt_in;
   logic [SCW-1:0] sensor_cnt_ff, sensor_cnt_in;
   logic [2:0]     field_ff, field_in;
   logic [31:0]    ctime_ff, ctime_in;
   logic [7:0]     tag_ff, tag_in;
   logic [23:0]    value_ff, value_in;
   logic           done_ff, done_in;
   logic           chunk_head_ff, chunk_head_in;

   logic [7:0]       b;
   logic             sop;
   logic [3:0]       pos;
   logic [1:0]       lane;
   logic [EXP_W-1:0] expected;
   logic [8:0]       sensor_next_ext, chunk_next_ext;
   logic             last_sensor, last_chunk;
   logic [CCW+5:0]   chunk_num_ext;
   logic [SCW+4:0]   sensor_num_ext;

   assign b   = item.data_byte;
   assign sop = item.start_of_packet;
   assign pos = sop ? spd_pkg::POS_TYPE : pos_ff;
   assign lane = pos[1:0] + 2'd2;

   assign expected = EXP_W'(spd_pkg::HEADER_BYTES) + EXP_W'(chunk_total_ff) *
                     (EXP_W'(spd_pkg::CHUNK_HEAD_BYTES) +
                      EXP_W'(spd_pkg::DATAPOINT_BYTES) * EXP_W'(b));

   assign sensor_next_ext = 9'(sensor_cnt_ff) + 9'd1;
   assign chunk_next_ext  = 9'(chunk_cnt_ff) + 9'd1;
   assign last_sensor     = sensor_next_ext >= {1'b0, sensor_total_ff};
   assign last_chunk      = chunk_next_ext >= {1'b0, chunk_total_ff};
   assign chunk_num_ext   = {6'd0, chunk_cnt_ff};
   assign sensor_num_ext  = {5'd0, sensor_cnt_ff};

   always_comb begin
      pos_in          = pos_ff;
      length_in       = length_ff;
      version_in      = version_ff;
      ptime_in        = ptime_ff;
      chunk_total_in  = chunk_total_ff;
      sensor_total_in = sensor_total_ff;
      chunk_cnt_in    = chunk_cnt_ff;
      sensor_cnt_in   = sensor_cnt_ff;
      field_in        = field_ff;
      ctime_in        = ctime_ff;
      tag_in          = tag_ff;
      value_in        = value_ff;
      done_in         = done_ff;
      chunk_head_in   = chunk_head_ff;
      result          = '0;
      result_valid    = 1'b0;

      if (step && (sop || !done_ff)) begin
         if (sop) begin
            length_in     = item.packet_length;
            chunk_cnt_in  = '0;
            sensor_cnt_in = '0;
            field_in      = '0;
            chunk_head_in = 1'b1;
            done_in       = 1'b0;
         end
         if (pos != spd_pkg::POS_BODY) begin
            pos_in = pos + 4'd1;
         end

         if (pos == spd_pkg::POS_TYPE) begin
            if (item.packet_length < 16'(spd_pkg::HEADER_BYTES) || b != {4'd0, type_code}) begin
               result.result_kind    = spd_pkg::KIND_STATUS;
               result.status_code    = spd_pkg::STATUS_BAD_HEADER;
               result.last_of_packet = 1'b1;
               result_valid          = 1'b1;
               done_in               = 1'b1;
            end
         end else if (pos == spd_pkg::POS_VERSION) begin
            version_in = b;
         end else if (pos <= spd_pkg::POS_TIME_HI) begin
            ptime_in[{lane, 3'b000} +: 8] = b;
         end else if (pos == spd_pkg::POS_CHUNKS) begin
            chunk_total_in = b;
         end else if (pos == spd_pkg::POS_SENSORS) begin
            sensor_total_in              = b;
            result.result_kind           = spd_pkg::KIND_STATUS;
            result.packet_version        = version_ff;
            result.packet_time           = ptime_ff;
            result.last_of_packet        = 1'b1;
            // checks in priority order: sensors, chunks, size
            if (b == 8'd0 || b > 8'(MAX_SENSORS)) begin
               result.status_code = spd_pkg::STATUS_BAD_SENSORS;
               result_valid       = 1'b1;
            end else if (chunk_total_ff == 8'd0 || chunk_total_ff > 8'(MAX_CHUNKS)) begin
               result.status_code = spd_pkg::STATUS_BAD_CHUNKS;
               result_valid       = 1'b1;
            end else if (32'(expected) > 32'(length_ff)) begin
               result.status_code = spd_pkg::STATUS_TRUNCATED;
               result_valid       = 1'b1;
            end
            done_in = result_valid;
         end else if (chunk_head_ff) begin
            ctime_in[{field_ff[1:0], 3'b000} +: 8] = b;
            if (field_ff == spd_pkg::FIELD_LAST_TIME) begin
               field_in      = '0;
               chunk_head_in = 1'b0;
            end else begin
               field_in = field_ff + 3'd1;
            end
         end else if (field_ff == 3'd0) begin
            tag_in   = b;
            field_in = 3'd1;
         end else if (field_ff != spd_pkg::FIELD_LAST_VALUE) begin
            value_in[{field_ff[1:0] - 2'd1, 3'b000} +: 8] = b;
            field_in = field_ff + 3'd1;
         end else begin
            // final value byte completes the datapoint
            field_in              = '0;
            result.result_kind    = spd_pkg::KIND_DATAPOINT;
            result.status_code    = spd_pkg::STATUS_OK;
            result.packet_version = version_ff;
            result.packet_time    = ptime_ff;
            result.chunk_number   = chunk_num_ext[5:0];
            result.chunk_time     = ctime_ff;
            result.sensor_number  = sensor_num_ext[4:0];
            result.sensor_tag     = tag_ff;
            result.sensor_value   = {b, value_ff};
            result.last_of_packet = last_sensor && last_chunk;
            result_valid          = 1'b1;
            if (last_sensor && last_chunk) begin
               done_in = 1'b1;
            end else if (last_sensor) begin
               sensor_cnt_in = '0;
               chunk_cnt_in  = chunk_cnt_ff + CCW'(1);
               chunk_head_in = 1'b1;
            end else begin
               sensor_cnt_in = sensor_cnt_ff + SCW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= spd_pkg::POS_TYPE;
         length_ff       <= '0;
         version_ff      <= '0;
         ptime_ff        <= '0;
         chunk_total_ff  <= '0;
         sensor_total_ff <= '0;
         chunk_cnt_ff    <= '0;
         sensor_cnt_ff   <= '0;
         field_ff        <= '0;
         done_ff         <= 1'b1;
         chunk_head_ff   <= 1'b1;
      end else begin
         pos_ff          <= pos_in;
         length_ff       <= length_in;
         version_ff      <= version_in;
         ptime_ff        <= ptime_in;
         chunk_total_ff  <= chunk_total_in;
         sensor_total_ff <= sensor_total_in;
         chunk_cnt_ff    <= chunk_cnt_in;
         sensor_cnt_ff   <= sensor_cnt_in;
         field_ff        <= field_in;
         done_ff         <= done_in;
         chunk_head_ff   <= chunk_head_in;
      end
   end

   // assembly registers: every byte lane is written before it is read
   always_ff @(posedge clock) begin
      ctime_ff <= ctime_in;
      tag_ff   <= tag_in;
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/sensor_packet_deframer_core.sv
// Top level of the sensor packet deframer: handshakes, type register, result register.
`default_nettype none

// Takes one packet byte per cycle and gives at most one result per byte: a datapoint when its
// last value byte arrives, or one status result when the header, the counts or the packet size
// fail their checks. Each transfer is parsed in the cycle it is accepted and the result lands in
// a single output register, so the rate is one byte per cycle; req_ready drops only while that
// register is full and not being taken. The result shows on rsp_valid in the cycle after the closing byte is accepted.
// Bytes outside a packet and trailing bytes are dropped without a result.
module sensor_packet_deframer_core #(
   parameter int MAX_SENSORS = spd_pkg::MAX_SENSORS_DEFAULT,
   parameter int MAX_CHUNKS  = spd_pkg::MAX_CHUNKS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire spd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output spd_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [3:0]       csr_write_data
);

   logic [3:0]       type_code_ff, type_code_in;
   logic             rsp_valid_ff, rsp_valid_in;
   spd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   spd_pkg::rsp_type step_result;
   logic             step_result_valid;
   logic             req_transfer;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   spd_parser #(
      .MAX_SENSORS (MAX_SENSORS),
      .MAX_CHUNKS  (MAX_CHUNKS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (req_transfer),
      .item         (req_data),
      .type_code    (type_code_ff),
      .result       (step_result),
      .result_valid (step_result_valid)
   );

   always_comb begin
      type_code_in = csr_write_enable ? csr_write_data : type_code_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_transfer && step_result_valid) begin
         rsp_data_in  = step_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_code_ff <= spd_pkg::TYPE_CODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         type_code_ff <= type_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
